FILE: sv/otsb_pkg.sv
// shared types and constants of the one-shot timer slot bank
package otsb_pkg;

	localparam int COUNT_W  = 32;
	localparam int DELAY_W  = 32;
	localparam int TAG_IN_W = 8;
	localparam int TAG_OUT_W = 8;
	localparam int SLOT_W   = 2;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_FIRE = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic                 kind;
		logic                 status;
		logic [SLOT_W-1:0]    slot;
		logic [TAG_OUT_W-1:0] tag;
		logic                 last;
	} result_t;

endpackage

FILE: sv/otsb_ram.sv
// generic single-write, single-read ram with registered read data
module otsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/otsb_ctrl.sv
// slot allocation, tick counter and deadline scan over the slot ram
module otsb_ctrl #(
	parameter int NUM_SLOTS = 4,
	parameter int TAG_WIDTH = 8
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           in_valid,
	output logic                                           in_stall,
	input  logic                                           operation,
	input  logic [otsb_pkg::DELAY_W-1:0]                   delay,
	input  logic [otsb_pkg::TAG_IN_W-1:0]                  handler_id,
	input  logic                                           out_free,
	output logic                                           res_load,
	output otsb_pkg::result_t                              res,
	output logic                                           ram_we,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_waddr,
	output logic [otsb_pkg::COUNT_W+TAG_WIDTH-1:0]         ram_wdata,
	output logic                                           ram_re,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_raddr,
	input  logic [otsb_pkg::COUNT_W+TAG_WIDTH-1:0]         ram_rdata
);

	import otsb_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                 state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 pend_valid_q;
	logic [IDX_W-1:0]     pend_slot_q;
	logic [TAG_WIDTH-1:0] pend_tag_q;

	logic                 accept;
	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic [COUNT_W-1:0]   rd_deadline;
	logic [TAG_WIDTH-1:0] rd_tag;
	logic [TAG_WIDTH-1:0] new_tag;
	logic                 fire_s1;
	logic                 hold_s1;
	logic                 issue_done;
	logic                 finish;
	logic [31:0]          tag_in_wide;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[SLOT_W-1:0];
	endfunction

	function automatic logic [TAG_OUT_W-1:0] to_tag(input logic [TAG_WIDTH-1:0] t);
		logic [31:0] w;
		w = 32'(t);
		return w[TAG_OUT_W-1:0];
	endfunction

	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign tag_in_wide = 32'(handler_id);
	assign new_tag     = tag_in_wide[TAG_WIDTH-1:0];

	assign rd_deadline = ram_rdata[COUNT_W+TAG_WIDTH-1:TAG_WIDTH];
	assign rd_tag      = ram_rdata[TAG_WIDTH-1:0];

	// adds only happen while idle and the scan only reads, so no same-entry overlap
	assign fire_s1    = valid_s1 && active_q[idx_s1] && (count_q > rd_deadline);
	assign hold_s1    = fire_s1 && pend_valid_q && !out_free;
	assign issue_done = (rd_cnt_q == CNT_W'(NUM_SLOTS));
	assign ram_re     = (state_q == ST_SCAN) && !issue_done && !hold_s1;
	assign ram_raddr  = rd_cnt_q[IDX_W-1:0];
	assign finish     = (state_q == ST_SCAN) && issue_done && !valid_s1 &&
			(!pend_valid_q || out_free);

	assign ram_we    = accept && (operation == OP_ADD) && free_found;
	assign ram_waddr = free_idx;
	assign ram_wdata = {count_q + delay, new_tag};

	always_comb begin
		res_load = 1'b0;
		res      = '0;
		if (accept && (operation == OP_ADD)) begin
			res_load   = 1'b1;
			res.kind   = KIND_ADD;
			res.status = free_found ? STATUS_OK : STATUS_FULL;
			res.slot   = free_found ? to_slot(free_idx) : '0;
			res.last   = 1'b1;
		end else if (fire_s1 && pend_valid_q && out_free) begin
			res_load = 1'b1;
			res.kind = KIND_FIRE;
			res.slot = to_slot(pend_slot_q);
			res.tag  = to_tag(pend_tag_q);
			res.last = 1'b0;
		end else if (finish && pend_valid_q) begin
			res_load = 1'b1;
			res.kind = KIND_FIRE;
			res.slot = to_slot(pend_slot_q);
			res.tag  = to_tag(pend_tag_q);
			res.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			active_q     <= '0;
			rd_cnt_q     <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept && (operation == OP_TICK)) begin
				count_q  <= count_q + 1'b1;
				state_q  <= ST_SCAN;
				rd_cnt_q <= '0;
			end
			if (ram_we) begin
				active_q[free_idx] <= 1'b1;
			end
			if (ram_re) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
				valid_s1 <= 1'b1;
			end else if (!hold_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1 && !hold_s1) begin
				active_q[idx_s1] <= 1'b0;
				pend_valid_q     <= 1'b1;
			end
			if (finish) begin
				state_q      <= ST_IDLE;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= ram_raddr;
		end
		if (fire_s1 && !hold_s1) begin
			pend_slot_q <= idx_s1;
			pend_tag_q  <= rd_tag;
		end
	end

endmodule

FILE: sv/one_shot_timer_slot_bank.sv
// top level of the one-shot timer slot bank: slot ram, control and result register
//
// usage
//  - input channel (in_valid / in_stall) carries one request per transaction:
//    operation add stores deadline = tick counter + delay and the handler tag in the
//    lowest free slot; operation tick advances the 32-bit counter and fires every
//    active slot whose deadline is strictly below the new count, slot 0 upward
//  - output channel (out_valid / out_stall) carries results: one reply per add,
//    zero to NUM_SLOTS fire reports per tick, last set on the final one
//  - add: reply sits in the output register in the cycle after acceptance; an add
//    starts no scan, so the bank stays idle
//  - tick: the slot ram is read one entry per cycle while the scan is not held;
//    the input stays stalled until the scan ends and the last report is loaded
//    into the output register
//  - a fired slot is held back one step so last can be set on the final report
//  - receiver stall holds the scan once a new fire finds the held report still
//    waiting on the output register; no result is dropped
//  - reset clears the counter, all slot active bits and the output valid;
//    the ram holds no reset state and needs no clearing pass
module one_shot_timer_slot_bank #(
	parameter int NUM_SLOTS = 4,
	parameter int TAG_WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [otsb_pkg::DELAY_W-1:0]      delay,
	input  logic [otsb_pkg::TAG_IN_W-1:0]     handler_id,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic                              status,
	output logic [otsb_pkg::SLOT_W-1:0]       slot,
	output logic [otsb_pkg::TAG_OUT_W-1:0]    fired_handler,
	output logic                              last
);

	import otsb_pkg::*;

	localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ENT_W  = COUNT_W + TAG_WIDTH;

	// ram port wires
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENT_W-1:0]  ram_rdata;

	// result handoff from control into the output register
	logic    out_free;
	logic    res_load;
	result_t res;

	logic    out_valid_q;
	result_t out_q;

	// output register can take a new result when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	// deadline and tag of each slot
	otsb_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	otsb_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.TAG_WIDTH (TAG_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.delay      (delay),
		.handler_id (handler_id),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, loaded only when free so a stalled result holds
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign status        = out_q.status;
	assign slot          = out_q.slot;
	assign fired_handler = out_q.tag;
	assign last          = out_q.last;

endmodule
